/* rtl/core/pcrq_pkg.sv */
// ----------------------------------------------------------------------------
// pcrq_pkg: shared types, constants and tables of the per-channel requantizer
// Holds the queue entry and configuration structs, the register index codes
// and the per-channel normalize multiplier and shift tables.
// ----------------------------------------------------------------------------
package pcrq_pkg;

  // Channel count; the channel index holds at the last of the 16 channels
  localparam int NUM_CH    = 16;
  localparam int CH_W      = 4;
  localparam int POS_W     = 20;
  localparam int SPC_W     = 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [SPC_W-1:0] SPC_MAX   = 21'd1048576;
  localparam logic [SPC_W-1:0] SPC_MIN   = 21'd1;
  localparam logic [SPC_W-1:0] SPC_RESET = 21'd32768;
  localparam logic [7:0]       FMUL_RESET   = 8'd5;
  localparam logic [3:0]       FSHIFT_RESET = 4'd4;
  localparam logic [7:0]       ZP_RESET     = 8'd0;

  localparam logic signed [7:0] SAT_HI = 8'sd127;
  localparam logic signed [7:0] SAT_LO = -8'sd128;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPC    = 2'd0,
    REG_FMUL   = 2'd1,
    REG_FSHIFT = 2'd2,
    REG_ZP     = 2'd3
  } cfg_reg_t;

  // Live configuration, already clamped where needed
  typedef struct packed {
    logic [SPC_W-1:0]   spc;
    logic [7:0]         fmul;
    logic [3:0]         fshift;
    logic signed [7:0]  zp;
  } cfg_t;

  // One classified sample between front and back
  typedef struct packed {
    logic signed [7:0] sample;
    logic [CH_W-1:0]   chan;
  } q_entry_t;

  // Normalize multiplier per channel
  function automatic logic [4:0] chan_gain(input logic [CH_W-1:0] ch);
    logic [4:0] m;
    case (ch[2:0])
      3'd0:    m = 5'd3;
      3'd1:    m = 5'd5;
      3'd2:    m = 5'd7;
      3'd3:    m = 5'd9;
      3'd4:    m = 5'd11;
      3'd5:    m = 5'd13;
      3'd6:    m = 5'd15;
      default: m = 5'd17;
    endcase
    return m;
  endfunction

  // Normalize shift per channel
  function automatic logic [2:0] chan_rshift(input logic [CH_W-1:0] ch);
    logic [2:0] s;
    case (ch[2:0])
      3'd0:    s = 3'd2;
      3'd1:    s = 3'd3;
      3'd2:    s = 3'd4;
      3'd3:    s = 3'd5;
      3'd4:    s = 3'd3;
      3'd5:    s = 3'd4;
      3'd6:    s = 3'd5;
      default: s = 3'd6;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/pcrq_front.sv */
// ----------------------------------------------------------------------------
// pcrq_front: sample intake and channel tracking
// Accepts samples, tracks position and channel index, and pushes each sample
// with its channel into the work queue.
// ----------------------------------------------------------------------------
module pcrq_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pcrq_pkg::cfg_t            cfg,
  input  logic                      in_push,
  input  logic                      in_first,
  input  logic signed [7:0]         in_sample,
  output logic                      in_full,
  input  logic                      q_full,
  output logic                      q_push,
  output pcrq_pkg::q_entry_t        q_entry
);
  import pcrq_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CH_W-1:0]  chan_r, chan_nxt;
  logic [POS_W-1:0] pos_cur;
  logic [CH_W-1:0]  chan_cur;
  logic [SPC_W-1:0] pos_inc;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // Restart counting on an array marker
  assign pos_cur  = in_first ? '0 : pos_r;
  assign chan_cur = in_first ? '0 : chan_r;
  assign pos_inc  = SPC_W'(pos_cur) + SPC_W'(1);

  assign q_entry.sample = in_sample;
  assign q_entry.chan   = chan_cur;

  // Advance position; step channel at the end of a channel, hold at the last
  always_comb begin
    pos_nxt  = pos_r;
    chan_nxt = chan_r;
    if (q_push) begin
      if (pos_inc >= cfg.spc) begin
        pos_nxt = '0;
        if (chan_cur != CH_W'(NUM_CH - 1)) begin
          chan_nxt = chan_cur + CH_W'(1);
        end else begin
          chan_nxt = chan_cur;
        end
      end else begin
        pos_nxt  = pos_inc[POS_W-1:0];
        chan_nxt = chan_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      chan_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      chan_r <= chan_nxt;
    end
  end

endmodule

/* rtl/core/pcrq_queue.sv */
// ----------------------------------------------------------------------------
// pcrq_queue: work queue between front and back
// Four-entry register queue of classified samples; decouples intake from
// the arithmetic pipeline.
// ----------------------------------------------------------------------------
module pcrq_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcrq_pkg::q_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output pcrq_pkg::q_entry_t  pop_data
);
  import pcrq_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  q_entry_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == (PTR_W+1)'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/pcrq_back.sv */
// ----------------------------------------------------------------------------
// pcrq_back: requantize arithmetic pipeline
// Four stages: normalize multiply, normalize round shift, final multiply,
// final round shift with zero point and int8 saturation into the result
// register.
// ----------------------------------------------------------------------------
module pcrq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pcrq_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  pcrq_pkg::q_entry_t  q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [7:0]   out_result
);
  import pcrq_pkg::*;

  // Stage valids and ready chain
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // Stage payloads
  logic signed [12:0] prod_a_r, prod_a_nxt;
  logic [2:0]         nsh_a_r;
  logic signed [8:0]  norm_b_r, norm_b_nxt;
  logic signed [17:0] prod_c_r, prod_c_nxt;
  logic signed [7:0]  res_d_r, res_d_nxt;

  // Stage A helpers
  logic signed [12:0] samp_ext, mult_ext;
  // Stage B helpers
  logic [12:0]        neg_a;
  logic [11:0]        mag_a;
  logic [12:0]        half_a, sum_a, shr_a;
  logic [8:0]         nmag_b;
  // Stage C helpers
  logic signed [17:0] norm_ext, fmul_ext;
  // Stage D helpers
  logic [17:0]        neg_c;
  logic [16:0]        mag_c;
  logic [17:0]        half_c, sum_c, shr_c;
  logic signed [17:0] rnd_d;
  logic signed [19:0] biased;

  assign rdy_d = !vld_d_r || out_pop;
  assign rdy_c = !vld_c_r || rdy_d;
  assign rdy_b = !vld_b_r || rdy_c;
  assign rdy_a = !vld_a_r || rdy_b;
  assign q_pop = q_valid && rdy_a;

  assign out_empty  = !vld_d_r;
  assign out_result = res_d_r;

  // Stage A: sample times channel multiplier
  always_comb begin
    samp_ext   = 13'(q_data.sample);
    mult_ext   = $signed({8'b0, chan_gain(q_data.chan)});
    prod_a_nxt = samp_ext * mult_ext;
  end

  // Stage B: round half away from zero, shift by channel shift
  always_comb begin
    neg_a      = 13'(-prod_a_r);
    mag_a      = prod_a_r[12] ? neg_a[11:0] : prod_a_r[11:0];
    half_a     = (nsh_a_r == '0) ? '0 : (13'(1) << (nsh_a_r - 3'd1));
    sum_a      = {1'b0, mag_a} + half_a;
    shr_a      = sum_a >> nsh_a_r;
    nmag_b     = {1'b0, shr_a[7:0]};
    norm_b_nxt = prod_a_r[12] ? $signed(-nmag_b) : $signed(nmag_b);
  end

  // Stage C: normalized value times final multiplier
  always_comb begin
    norm_ext   = 18'(norm_b_r);
    fmul_ext   = $signed({10'b0, cfg.fmul});
    prod_c_nxt = norm_ext * fmul_ext;
  end

  // Stage D: final round shift, add zero point, saturate to int8
  always_comb begin
    neg_c  = 18'(-prod_c_r);
    mag_c  = prod_c_r[17] ? neg_c[16:0] : prod_c_r[16:0];
    half_c = (cfg.fshift == '0) ? '0 : (18'(1) << (cfg.fshift - 4'd1));
    sum_c  = {1'b0, mag_c} + half_c;
    shr_c  = sum_c >> cfg.fshift;
    rnd_d  = prod_c_r[17] ? $signed(-{1'b0, shr_c[16:0]}) : $signed({1'b0, shr_c[16:0]});
    biased = 20'(rnd_d) + 20'(cfg.zp);
    if (biased > 20'(SAT_HI)) begin
      res_d_nxt = SAT_HI;
    end else if (biased < 20'(SAT_LO)) begin
      res_d_nxt = SAT_LO;
    end else begin
      res_d_nxt = biased[7:0];
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      if (rdy_a) vld_a_r <= q_valid;
      if (rdy_b) vld_b_r <= vld_a_r;
      if (rdy_c) vld_c_r <= vld_b_r;
      if (rdy_d) vld_d_r <= vld_c_r;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      prod_a_r <= prod_a_nxt;
      nsh_a_r  <= chan_rshift(q_data.chan);
    end
    if (rdy_b) norm_b_r <= norm_b_nxt;
    if (rdy_c) prod_c_r <= prod_c_nxt;
    if (rdy_d) res_d_r  <= res_d_nxt;
  end

endmodule

/* rtl/core/per_channel_int8_requantizer.sv */
// ----------------------------------------------------------------------------
// per_channel_int8_requantizer: per-channel int8 requantization
// Tracks the channel of each streamed sample and requantizes it with the
// channel's normalize multiplier/shift, then the global multiplier/shift,
// zero point and int8 saturation.
//
//   Channel  Handshake          Payload
//   in_      in_push / in_full  in_sample[7:0] signed, in_first
//   out_     out_pop / out_empty out_result[7:0] signed
//   cfg_     cfg_valid/cfg_ready cfg_index[1:0], cfg_data[20:0]
//
// One sample per cycle while results are popped; the accepting edge writes the
// work queue, then the sample passes stage registers A, B, C and D, the last
// being the result register that drives out_result, from which it is popped.
// Holding out_pop low backs up the stages, then the 4-entry queue, then
// raises in_full. cfg_ready is always high.
// Synchronous active-low reset clears counters, queue and stages and loads
// the register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
module per_channel_int8_requantizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [7:0]                 in_sample,
  input  logic                              in_first,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [7:0]                 out_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcrq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcrq_pkg::SPC_W-1:0]        cfg_data
);
  import pcrq_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       q_push, q_full, q_pop, q_valid;
  q_entry_t   q_in, q_out;
  logic       cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Decode register writes; clamp samples per channel to its legal range
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPC: begin
          if (cfg_data == '0) begin
            cfg_nxt.spc = SPC_MIN;
          end else if (cfg_data > SPC_MAX) begin
            cfg_nxt.spc = SPC_MAX;
          end else begin
            cfg_nxt.spc = cfg_data;
          end
        end
        REG_FMUL:   cfg_nxt.fmul   = cfg_data[7:0];
        REG_FSHIFT: cfg_nxt.fshift = cfg_data[3:0];
        REG_ZP:     cfg_nxt.zp     = $signed(cfg_data[7:0]);
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spc    <= SPC_RESET;
      cfg_r.fmul   <= FMUL_RESET;
      cfg_r.fshift <= FSHIFT_RESET;
      cfg_r.zp     <= $signed(ZP_RESET);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcrq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_push   (in_push),
    .in_first  (in_first),
    .in_sample (in_sample),
    .in_full   (in_full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  pcrq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  pcrq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full work queue");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

  // Queue stays empty without a push
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_valid && !q_push) |=> !q_valid)
    else $error("work queue filled without a push");

  // Nothing leaves the queue while it is empty
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty work queue");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the per-channel int8 requantizer
// Streams signed samples through the input queue port and predicts each
// requantized result in the bench. It checks every popped result in order.
// The tests cover reset defaults, a walk over every channel, the clamp of
// samples-per-channel and long random array traffic under several register
// settings and handshake idling mixes.
// ----------------------------------------------------------------------------
module testbench;
  import pcrq_pkg::*;

  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int PHASE_SETTINGS    = 5;
  localparam int ITEMS_PER_SETTING = 90;
  localparam int MAX_REPORTS       = 50;

  // Stimulus and clocking
  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_push   = 1'b0;
  logic signed [7:0]        in_sample = '0;
  logic                     in_first  = 1'b0;
  logic                     out_pop   = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [SPC_W-1:0]         cfg_data  = '0;
  logic                     in_full;
  logic                     out_empty;
  logic signed [7:0]        out_result;
  logic                     cfg_ready;

  // Predicted register file and channel tracking, at reset values
  logic [SPC_W-1:0]         spc_cfg     = SPC_RESET;
  logic [7:0]               fmul_cfg    = FMUL_RESET;
  logic [3:0]               fshift_cfg  = FSHIFT_RESET;
  logic signed [7:0]        zp_cfg      = ZP_RESET;
  logic [POS_W-1:0]         pos_in_chan = '0;
  logic [CH_W-1:0]          chan_idx    = '0;

  int gain_lut   [NUM_CH] = '{3, 5, 7, 9, 11, 13, 15, 17, 3, 5, 7, 9, 11, 13, 15, 17};
  int rshift_lut [NUM_CH] = '{2, 3, 4, 5, 3, 4, 5, 6, 2, 3, 4, 5, 3, 4, 5, 6};

  logic signed [7:0] pending_results [$];

  int error_count      = 0;
  int samples_sent     = 0;
  int results_checked  = 0;
  int settings_applied = 0;
  int send_idle_pct    = 0;
  int pop_stall_pct    = 0;
  int quiet_cycles     = 0;

  per_channel_int8_requantizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_sample  (in_sample),
    .in_first   (in_first),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Right shift, rounding half away from zero
  function automatic int round_half_away(input int value, input int sh);
    int mag;
    int rounded;
    mag = (value < 0) ? -value : value;
    rounded = (sh == 0) ? mag : ((mag + (1 << (sh - 1))) >> sh);
    return (value < 0) ? -rounded : rounded;
  endfunction

  // Predict one requantized result and advance the channel tracking
  function automatic logic signed [7:0] requantize(input logic signed [7:0] value,
                                                   input logic mark);
    int spc_eff;
    int norm;
    int scaled;
    spc_eff = (spc_cfg == '0) ? 1 : ((spc_cfg > SPC_MAX) ? int'(SPC_MAX) : int'(spc_cfg));
    if (mark) begin
      pos_in_chan = '0;
      chan_idx    = '0;
    end
    norm   = round_half_away(int'(value) * gain_lut[chan_idx], rshift_lut[chan_idx]);
    scaled = round_half_away(norm * int'(fmul_cfg), int'(fshift_cfg)) + int'(zp_cfg);
    if (scaled > int'(SAT_HI)) scaled = int'(SAT_HI);
    if (scaled < int'(SAT_LO)) scaled = int'(SAT_LO);
    // Step to the next channel once this one is full; hold at the last
    if (int'(pos_in_chan) + 1 >= spc_eff) begin
      pos_in_chan = '0;
      if (chan_idx != CH_W'(NUM_CH - 1)) chan_idx = chan_idx + 1'b1;
    end else begin
      pos_in_chan = pos_in_chan + 1'b1;
    end
    return scaled[7:0];
  endfunction

  // Pick a sample, biased toward the range corners
  function automatic logic signed [7:0] random_sample();
    case ($urandom_range(9))
      0:       return 8'sh80;
      1:       return 8'sh7f;
      2:       return 8'shff;
      3:       return 8'sh00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send one sample transaction, with random idle cycles ahead of it
  task automatic send_sample(input logic signed [7:0] value, input logic mark);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push   <= 1'b1;
    in_sample <= value;
    in_first  <= mark;
    do @(posedge clk); while (in_full);
    pending_results.push_back(requantize(value, mark));
    samples_sent++;
  endtask

  // Drop push and wait until every expected result has been popped
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; leave valid high for a following write
  task automatic write_reg(input cfg_reg_t idx, input logic [SPC_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPC:    spc_cfg    = data;
      REG_FMUL:   fmul_cfg   = data[7:0];
      REG_FSHIFT: fshift_cfg = data[3:0];
      REG_ZP:     zp_cfg     = data[7:0];
    endcase
  endtask

  // Load a full register setting while the block is idle
  task automatic apply_config(input logic [SPC_W-1:0] spc, input logic [7:0] fmul,
                              input logic [3:0] fshift, input logic signed [7:0] zp);
    logic [SPC_W-1:0] noise;
    noise = SPC_W'($urandom);
    settle();
    // Unused upper data bits carry noise; the block must ignore them
    write_reg(REG_SPC, spc);
    write_reg(REG_FMUL, {noise[SPC_W-1:8], fmul});
    write_reg(REG_FSHIFT, {noise[SPC_W-1:4], fshift});
    write_reg(REG_ZP, {noise[SPC_W-1:8], zp});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Run the range corners through the reset-default settings
  task automatic test_reset_defaults();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_sample(8'sh7f, 1'b1);
    send_sample(8'sh80, 1'b0);
    send_sample(8'sh00, 1'b0);
    send_sample(8'shff, 1'b0);
    send_sample(8'sh01, 1'b0);
  endtask

  // Zero samples per channel acts as one: walk every channel and past the last,
  // with no final shift, then restart with a first marker
  task automatic test_channel_walk();
    int i;
    apply_config('0, 8'd1, 4'd0, 8'sd64);
    for (i = 0; i < NUM_CH + 1; i++) begin
      send_sample((i % 2 == 0) ? 8'sh7f : 8'sh80, i == 0);
    end
    send_sample(8'sh80, 1'b1);
  endtask

  // Oversized samples per channel, full multiplier and shift, low saturation
  task automatic test_spc_clamp();
    apply_config({SPC_W{1'b1}}, 8'd255, 4'd15, 8'sh80);
    send_sample(8'sh80, 1'b1);
    send_sample(8'sh7f, 1'b0);
  endtask

  // Random arrays under random settings and each idling mix
  task automatic test_random_traffic();
    int phase;
    int k;
    int i;
    int left;
    int run_len;
    int max_run;
    int spc_eff;
    logic [SPC_W-1:0]  spc_pick;
    logic [7:0]        fmul_pick;
    logic [3:0]        fshift_pick;
    logic signed [7:0] zp_pick;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; pop_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  pop_stall_pct = 60; end
        default: begin send_idle_pct = 17; pop_stall_pct = 17; end
      endcase
      for (k = 0; k < PHASE_SETTINGS; k++) begin
        // First two settings of a phase sit at the register extremes
        if (k == 0) begin
          spc_pick = SPC_MIN; fmul_pick = 8'd0; fshift_pick = 4'd0; zp_pick = 8'sh80;
        end else if (k == 1) begin
          spc_pick = '0; fmul_pick = 8'd255; fshift_pick = 4'd15; zp_pick = 8'sh7f;
        end else begin
          case ($urandom_range(9))
            0:       spc_pick = SPC_W'($urandom);
            1, 2:    spc_pick = SPC_W'($urandom_range(7, 40));
            default: spc_pick = SPC_W'($urandom_range(0, 6));
          endcase
          fmul_pick   = 8'($urandom);
          fshift_pick = 4'($urandom);
          zp_pick     = 8'($urandom);
        end
        apply_config(spc_pick, fmul_pick, fshift_pick, zp_pick);
        spc_eff = (spc_pick == '0) ? 1 : ((spc_pick > 40) ? 1000 : int'(spc_pick));
        max_run = (spc_eff <= 6) ? 16 * spc_eff + 4 : 40;
        left = ITEMS_PER_SETTING;
        while (left > 0) begin
          if ($urandom_range(99) < 85) begin
            // Well-formed array: marker on the first sample only
            run_len = $urandom_range(1, max_run);
            if (run_len > left) run_len = left;
            for (i = 0; i < run_len; i++) send_sample(random_sample(), i == 0);
          end else begin
            // Noise: markers at random
            run_len = $urandom_range(1, 6);
            if (run_len > left) run_len = left;
            for (i = 0; i < run_len; i++) send_sample(random_sample(), 1'($urandom));
          end
          left -= run_len;
        end
      end
    end
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Compare each popped result with the oldest prediction
  always @(posedge clk) begin : check_results
    logic signed [7:0] want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $error("result: unexpected transaction, expected none, actual %0d", out_result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result !== want) begin
          if (error_count < MAX_REPORTS)
            $error("result mismatch: expected %0d, actual %0d", want, out_result);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it at a falling clock edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_channel_walk();
    test_spc_clamp();
    test_random_traffic();
    settle();
    $display("Checked %0d results from %0d samples over %0d register settings,",
             results_checked, samples_sent, settings_applied);
    $display("with channel walk, clamping, saturation and four idling mixes.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
